/* rtl/core/kest_pkg.sv */
// Shared types and constants for the key edge state table.
// Used by kest_cell and key_edge_state_table_core; depends on nothing.
package kest_pkg;

   localparam int TABLE_ENTRIES_DEF = 16;
   localparam int KEY_BITS_DEF      = 25;
   localparam int KEY_CODE_W        = 25;
   localparam int COMMAND_W         = 3;
   localparam int PHASE_W           = 2;

   typedef enum logic [COMMAND_W-1:0] {
      CMD_PRESS   = 3'd0,
      CMD_RELEASE = 3'd1,
      CMD_TICK    = 3'd2,
      CMD_QUERY   = 3'd3,
      CMD_CLEAR   = 3'd4
   } cmd_type;

   typedef enum logic [PHASE_W-1:0] {
      PHASE_ABSENT    = 2'd0,
      PHASE_TRIGGERED = 2'd1,
      PHASE_PRESSED   = 2'd2,
      PHASE_RELEASED  = 2'd3
   } phase_type;

   // Operation walking down the cell chain, one cell per cycle
   typedef struct packed {
      logic      valid;
      cmd_type   cmd;
      logic      hit;        // key found in an earlier cell
      phase_type phase;      // phase of that entry after the operation
      logic      free_seen;  // an earlier cell has reserved its free slot
   } token_type;

   // Broadcast from the tail once the walk is finished
   typedef struct packed {
      logic go;      // operation retires this cycle
      logic insert;  // reserved cell takes the key
   } commit_type;

endpackage

/* rtl/core/key_edge_state_table_core.sv */
// Top level of the key edge state table: request register, chain of kest_cell
// entries, tail/commit logic and response register. Depends on kest_pkg, kest_cell.
//
//  Channel | Ports                                     | Direction
//  --------+-------------------------------------------+----------
//  req     | req_valid, req_stall, req_command,        | in
//          | req_key_code                              |
//  rsp     | rsp_valid, rsp_stall, rsp_key_phase,      | out
//          | rsp_dropped                               |
//
// One operation at a time: it walks the cell chain one entry per cycle, so
// rsp_valid rises after it has passed the head register, every cell and the
// tail register, and the next request is taken only once it has retired; the
// throughput is set by the chain length. req_stall is high while an operation
// is in flight; a stalled response holds the finished operation in the tail.
// Synchronous reset empties the table in the same cycle. A stalled response
// is held in the output register while the next request is taken.
module key_edge_state_table_core #(
   parameter int TABLE_ENTRIES = kest_pkg::TABLE_ENTRIES_DEF,
   parameter int KEY_BITS      = kest_pkg::KEY_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [kest_pkg::COMMAND_W-1:0]    req_command,
   input  logic [kest_pkg::KEY_CODE_W-1:0]   req_key_code,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [kest_pkg::PHASE_W-1:0]      rsp_key_phase,
   output logic                              rsp_dropped
);

   logic                         busy_ff, busy_in;
   logic [KEY_BITS-1:0]          key_ff, key_in, key_ext;
   kest_pkg::token_type          head_ff, head_in;
   kest_pkg::token_type          tail_ff, tail_in;
   kest_pkg::token_type          chain [TABLE_ENTRIES+1];
   kest_pkg::commit_type         commit;
   logic                         rsp_valid_ff, rsp_valid_in;
   kest_pkg::phase_type          rsp_phase_ff, rsp_phase_in;
   logic                         rsp_dropped_ff, rsp_dropped_in;
   logic                         accept;
   logic                         fresh_press;

   generate
      if (KEY_BITS <= kest_pkg::KEY_CODE_W) begin : g_key_cut
         assign key_ext = req_key_code[KEY_BITS-1:0];
      end else begin : g_key_ext
         assign key_ext = {{(KEY_BITS-kest_pkg::KEY_CODE_W){1'b0}}, req_key_code};
      end
   endgenerate

   assign chain[0] = head_ff;

   generate
      for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
         kest_cell #(
            .KEY_BITS (KEY_BITS)
         ) u_cell (
            .clock   (clock),
            .reset   (reset),
            .key     (key_ff),
            .tok_in  (chain[i]),
            .commit  (commit),
            .tok_out (chain[i+1])
         );
      end
   endgenerate

   always_comb begin
      accept = req_valid && !busy_ff;

      head_in           = head_ff;
      head_in.valid     = accept;
      head_in.cmd       = kest_pkg::cmd_type'(req_command);
      head_in.hit       = 1'b0;
      head_in.phase     = kest_pkg::PHASE_ABSENT;
      head_in.free_seen = 1'b0;

      key_in = accept ? key_ext : key_ff;

      commit.go   = tail_ff.valid && (!rsp_valid_ff || !rsp_stall);
      fresh_press = (tail_ff.cmd == kest_pkg::CMD_PRESS) && !tail_ff.hit;
      commit.insert = commit.go && fresh_press && tail_ff.free_seen;

      tail_in = tail_ff;
      if (chain[TABLE_ENTRIES].valid) begin
         tail_in = chain[TABLE_ENTRIES];
      end else if (commit.go) begin
         tail_in.valid = 1'b0;
      end

      rsp_phase_in   = rsp_phase_ff;
      rsp_dropped_in = rsp_dropped_ff;
      if (commit.go) begin
         if (fresh_press) begin
            rsp_phase_in   = tail_ff.free_seen ? kest_pkg::PHASE_TRIGGERED
                                               : kest_pkg::PHASE_ABSENT;
            rsp_dropped_in = !tail_ff.free_seen;
         end else begin
            rsp_phase_in   = tail_ff.hit ? tail_ff.phase : kest_pkg::PHASE_ABSENT;
            rsp_dropped_in = 1'b0;
         end
      end

      priority if (commit.go) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      priority if (accept) begin
         busy_in = 1'b1;
      end else if (commit.go) begin
         busy_in = 1'b0;
      end else begin
         busy_in = busy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         head_ff.valid <= 1'b0;
         tail_ff.valid <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff         <= key_in;
      rsp_phase_ff   <= rsp_phase_in;
      rsp_dropped_ff <= rsp_dropped_in;
   end

   assign req_stall     = busy_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_key_phase = rsp_phase_ff;
   assign rsp_dropped   = rsp_dropped_ff;

endmodule

/* rtl/core/kest_cell.sv */
// One table entry of the key edge state table plus its stage of the token chain.
// Depends on kest_pkg.
module kest_cell #(
   parameter int KEY_BITS = kest_pkg::KEY_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [KEY_BITS-1:0]   key,
   input  kest_pkg::token_type   tok_in,
   input  kest_pkg::commit_type  commit,
   output kest_pkg::token_type   tok_out
);

   logic                 valid_ff, valid_in;
   kest_pkg::phase_type  phase_ff, phase_in;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic                 pend_ff, pend_in;
   kest_pkg::token_type  pass_ff, pass_in;
   logic                 match;

   always_comb begin
      valid_in = valid_ff;
      phase_in = phase_ff;
      key_in   = key_ff;
      pend_in  = pend_ff;
      pass_in  = tok_in;
      match    = valid_ff && (key_ff == key);

      if (tok_in.valid) begin
         unique case (tok_in.cmd)
            kest_pkg::CMD_PRESS: begin
               // lowest free entry is reserved; filled only if key absent everywhere
               if (!valid_ff && !tok_in.free_seen) begin
                  pend_in           = 1'b1;
                  pass_in.free_seen = 1'b1;
               end
            end
            kest_pkg::CMD_RELEASE: begin
               if (match) begin
                  phase_in = kest_pkg::PHASE_RELEASED;
               end
            end
            kest_pkg::CMD_TICK: begin
               if (valid_ff) begin
                  if (phase_ff == kest_pkg::PHASE_TRIGGERED) begin
                     phase_in = kest_pkg::PHASE_PRESSED;
                  end else if (phase_ff == kest_pkg::PHASE_RELEASED) begin
                     valid_in = 1'b0;
                     phase_in = kest_pkg::PHASE_ABSENT;
                  end
               end
            end
            kest_pkg::CMD_CLEAR: begin
               valid_in = 1'b0;
               phase_in = kest_pkg::PHASE_ABSENT;
            end
            default: begin
            end
         endcase

         if (match && valid_in) begin
            pass_in.hit   = 1'b1;
            pass_in.phase = phase_in;
         end
      end

      if (commit.go) begin
         pend_in = 1'b0;
         if (commit.insert && pend_ff) begin
            valid_in = 1'b1;
            key_in   = key;
            phase_in = kest_pkg::PHASE_TRIGGERED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= 1'b0;
         phase_ff      <= kest_pkg::PHASE_ABSENT;
         pend_ff       <= 1'b0;
         pass_ff.valid <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         phase_ff <= phase_in;
         pend_ff  <= pend_in;
         pass_ff  <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign tok_out = pass_ff;

endmodule

/* test/key_edge_state_table_checker.sv */
// Checker for the key edge state table: watches both channels, keeps its own copy of the
// table, predicts each answer and compares it with the response transfer.
// Depends on kest_pkg; instantiated beside the block by key_edge_state_table_core_tb.
module key_edge_state_table_checker #(
   parameter int TABLE_ENTRIES = kest_pkg::TABLE_ENTRIES_DEF,
   parameter int KEY_BITS      = kest_pkg::KEY_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [kest_pkg::COMMAND_W-1:0]  req_command,
   input  logic [kest_pkg::KEY_CODE_W-1:0] req_key_code,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [kest_pkg::PHASE_W-1:0]    rsp_key_phase,
   input  logic                            rsp_dropped,
   output int                              mismatch_count,
   output int                              answers_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int KEY_W = kest_pkg::KEY_CODE_W;
   localparam int CMD_W = kest_pkg::COMMAND_W;
   localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'((64'd1 << KEY_BITS) - 64'd1);

   typedef struct packed {
      kest_pkg::phase_type phase;
      logic                dropped;
   } key_answer_type;

   logic                tbl_used  [TABLE_ENTRIES];
   logic [KEY_W-1:0]    tbl_key   [TABLE_ENTRIES];
   kest_pkg::phase_type tbl_phase [TABLE_ENTRIES];
   key_answer_type      answers_due [$];

   function automatic int slot_of(input logic [KEY_W-1:0] key);
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (tbl_used[i] && tbl_key[i] == key) return i;
      end
      return -1;
   endfunction

   task automatic apply_key_event(input logic [CMD_W-1:0] cmd,
                                  input logic [KEY_W-1:0] key_in,
                                  output key_answer_type ans);
      logic [KEY_W-1:0] key;
      int hit;
      int free_slot;
      key = key_in & KEY_MASK;
      ans.dropped = 1'b0;
      hit = slot_of(key);
      case (cmd)
         kest_pkg::CMD_PRESS: begin
            if (hit < 0) begin
               // lowest free entry wins
               free_slot = -1;
               for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
                  if (!tbl_used[i]) free_slot = i;
               end
               if (free_slot < 0) begin
                  ans.dropped = 1'b1;
               end else begin
                  tbl_used[free_slot]  = 1'b1;
                  tbl_key[free_slot]   = key;
                  tbl_phase[free_slot] = kest_pkg::PHASE_TRIGGERED;
               end
            end
         end
         kest_pkg::CMD_RELEASE: begin
            if (hit >= 0) tbl_phase[hit] = kest_pkg::PHASE_RELEASED;
         end
         kest_pkg::CMD_TICK: begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               if (tbl_used[i] && tbl_phase[i] == kest_pkg::PHASE_TRIGGERED) begin
                  tbl_phase[i] = kest_pkg::PHASE_PRESSED;
               end else if (tbl_used[i] && tbl_phase[i] == kest_pkg::PHASE_RELEASED) begin
                  tbl_used[i]  = 1'b0;
                  tbl_phase[i] = kest_pkg::PHASE_ABSENT;
               end
            end
         end
         kest_pkg::CMD_CLEAR: begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
               tbl_used[i]  = 1'b0;
               tbl_phase[i] = kest_pkg::PHASE_ABSENT;
            end
         end
         default: ; // query and spare codes leave the table alone
      endcase
      hit = slot_of(key);
      ans.phase = (hit >= 0) ? tbl_phase[hit] : kest_pkg::PHASE_ABSENT;
   endtask

   always @(posedge clock) begin : watch_channels
      key_answer_type want;
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tbl_used[i]  = 1'b0;
            tbl_key[i]   = '0;
            tbl_phase[i] = kest_pkg::PHASE_ABSENT;
         end
         answers_due.delete();
      end else begin
         // response first: a transfer at this edge belongs to an older request
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               $display("%0t: unexpected response, key_phase %0d dropped %0d",
                        $time, rsp_key_phase, rsp_dropped);
               mismatch_count++;
            end else begin
               want = answers_due.pop_front();
               if (rsp_key_phase !== want.phase) begin
                  $display("%0t: key_phase expected %0d, got %0d",
                           $time, want.phase, rsp_key_phase);
                  mismatch_count++;
               end
               if (rsp_dropped !== want.dropped) begin
                  $display("%0t: dropped expected %0d, got %0d",
                           $time, want.dropped, rsp_dropped);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            apply_key_event(req_command, req_key_code, want);
            answers_due = {answers_due, want};
         end
      end
      answers_pending = answers_due.size();
   end

endmodule

/* test/key_edge_state_table_core_tb.sv */
// Testbench top for key_edge_state_table_core: clock, reset, request and stall stimulus,
// and the verdict. Depends on kest_pkg, the block and key_edge_state_table_checker.
module key_edge_state_table_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int KEY_W          = kest_pkg::KEY_CODE_W;
   localparam int CMD_W          = kest_pkg::COMMAND_W;
   localparam int CYCLE_LIMIT    = 400000;
   localparam int DRAIN_CYCLES   = kest_pkg::TABLE_ENTRIES_DEF + 8;
   localparam int RANDOM_EVENTS  = 700;
   localparam logic [KEY_W-1:0] KEY_ALL_ONES = '1;
   localparam logic [KEY_W-1:0] KEY_STRIPES  = 25'h155_5555;

   logic                          clock        = 1'b0;
   logic                          reset        = 1'b1;
   logic                          req_valid    = 1'b0;
   logic                          req_stall;
   logic [CMD_W-1:0]              req_command  = '0;
   logic [KEY_W-1:0]              req_key_code = '0;
   logic                          rsp_valid;
   logic                          rsp_stall    = 1'b0;
   logic [kest_pkg::PHASE_W-1:0]  rsp_key_phase;
   logic                          rsp_dropped;
   logic                          quiet        = 1'b0;
   int                            mismatch_count;
   int                            answers_pending;
   int                            cycle_count  = 0;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   key_edge_state_table_core DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_command   (req_command),
      .req_key_code  (req_key_code),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_key_phase (rsp_key_phase),
      .rsp_dropped   (rsp_dropped)
   );

   key_edge_state_table_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_key_code    (req_key_code),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_key_phase   (rsp_key_phase),
      .rsp_dropped     (rsp_dropped),
      .mismatch_count  (mismatch_count),
      .answers_pending (answers_pending)
   );

   always @(negedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 34);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Presents one request and returns at the edge where it is taken.
   task automatic issue_key_event(input logic [CMD_W-1:0] cmd,
                                  input logic [KEY_W-1:0] key);
      bit taken;
      @(negedge clock);
      if (!quiet && $urandom_range(99) < 34) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, kest_pkg::TABLE_ENTRIES_DEF + 4)) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_key_code <= key;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = !req_stall;
      end
   endtask

   task automatic wait_until_answered();
      @(negedge clock);
      req_valid <= 1'b0;
      while (answers_pending != 0) @(negedge clock);
   endtask

   // Mostly presses, releases and ticks on a small pool of keys so entries go
   // through their whole life and the table fills up; the rest is stray keys.
   task automatic random_key_events(input int count);
      logic [KEY_W-1:0] pool [24];
      logic [CMD_W-1:0] cmd;
      logic [KEY_W-1:0] key;
      int pool_size;
      int roll;
      for (int n = 0; n < count; n++) begin
         if (n % 100 == 0) begin
            if (n != 0) wait_until_answered();
            pool_size = $urandom_range(4, 24);
            foreach (pool[i]) pool[i] = KEY_W'($urandom);
         end
         quiet = (n >= 250 && n < 400);
         roll  = $urandom_range(99);
         if (roll < 38)      cmd = kest_pkg::CMD_PRESS;
         else if (roll < 55) cmd = kest_pkg::CMD_RELEASE;
         else if (roll < 70) cmd = kest_pkg::CMD_TICK;
         else if (roll < 96) cmd = kest_pkg::CMD_QUERY;
         else if (roll < 98) cmd = kest_pkg::CMD_CLEAR;
         else                cmd = CMD_W'($urandom_range(5, 7));
         if ($urandom_range(99) < 88) key = pool[$urandom_range(pool_size - 1)];
         else                         key = KEY_W'($urandom);
         issue_key_event(cmd, key);
      end
      quiet = 1'b0;
   endtask

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      issue_key_event(kest_pkg::CMD_PRESS, '0);
      issue_key_event(kest_pkg::CMD_PRESS, '0);            // already present
      issue_key_event(kest_pkg::CMD_RELEASE, KEY_ALL_ONES); // absent key
      issue_key_event(kest_pkg::CMD_TICK, '0);
      issue_key_event(kest_pkg::CMD_RELEASE, '0);
      issue_key_event(CMD_W'(5), '0);
      issue_key_event(CMD_W'(6), '0);
      issue_key_event(CMD_W'(7), '0);
      // key 0 still holds an entry, so fifteen more fill the table
      for (int i = 0; i < kest_pkg::TABLE_ENTRIES_DEF - 1; i++) begin
         issue_key_event(kest_pkg::CMD_PRESS, KEY_ALL_ONES ^ KEY_W'(i));
      end
      issue_key_event(kest_pkg::CMD_PRESS, KEY_STRIPES);   // table full
      issue_key_event(kest_pkg::CMD_TICK, KEY_ALL_ONES);
      issue_key_event(kest_pkg::CMD_QUERY, KEY_STRIPES);
      issue_key_event(kest_pkg::CMD_CLEAR, KEY_ALL_ONES);
      wait_until_answered();

      random_key_events(RANDOM_EVENTS);
      wait_until_answered();
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && answers_pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/kest_pkg.sv
rtl/core/kest_cell.sv
rtl/core/key_edge_state_table_core.sv
test/key_edge_state_table_checker.sv
test/key_edge_state_table_core_tb.sv
